@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the positioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is applied.
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positioner assertion failed");

// Next-cycle implication, suspended while reset is applied.
`define ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positioner assertion failed");

// Condition that must hold on the cycle after reset is sampled.
`define ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("positioner reset assertion failed");

`endif

@@ rtl/shsp_pkg.sv @@
// Shared types, constants and coil tables of the half-step positioner.
package shsp_pkg;

    localparam int STEPS_PER_BURST_DEF = 8;
    localparam int FRAC_BITS = 21;

    localparam logic signed [15:0] OFFSET_RST = 16'sd1024;
    localparam logic [19:0] GAIN_RST = 20'd166886;
    localparam logic signed [15:0] HOME_START_POS = 16'sd8;

    localparam logic CFG_TARGET_OFFSET = 1'b0;
    localparam logic CFG_ANGLE_GAIN = 1'b1;

    typedef enum logic [1:0] {
        CMD_SET_ANGLE = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_HOME = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_CCW = 2'd1,
        DIR_CW = 2'd2
    } t_dir;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SAT,
        S_DIR,
        S_UPD,
        S_STEP,
        S_HOME,
        S_OFF
    } t_state;

    typedef struct packed {
        logic cap;
        logic mul;
        logic sum;
        logic sat;
        logic set_dir;
        logic stop_dir;
        logic step;
        logic step_cw;
        logic emit_off;
        logic off_last;
        logic home_start;
        logic clr_pos;
    } t_dp_cmd;

    typedef struct packed {
        t_dir dir;
        logic ccw_reached;
        logic cw_reached;
        logic done_up;
        logic done_dn;
        logic out_free;
        logic sw;
    } t_dp_stat;

    function automatic logic [3:0] ccw_coils(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0: c = 4'h1;
            3'd1: c = 4'h3;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'hc;
            3'd6: c = 4'h8;
            default: c = 4'h9;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] cw_coils(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0: c = 4'h1;
            3'd1: c = 4'h9;
            3'd2: c = 4'h8;
            3'd3: c = 4'hc;
            3'd4: c = 4'h4;
            3'd5: c = 4'h6;
            3'd6: c = 4'h2;
            default: c = 4'h3;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/shsp_dp.sv @@
// Datapath of the positioner: registers, target arithmetic, stepping and output register.
module shsp_dp
    import shsp_pkg::*;
#(
    parameter int STEPS_PER_BURST = STEPS_PER_BURST_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [19:0]        i_cfg_data,
    input  logic signed [15:0] i_angle,
    input  logic               i_switch_high,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [3:0]         o_coils,
    output logic signed [15:0] o_position,
    output logic               o_finished,
    output logic               o_last
);

    localparam int IDX_W = (STEPS_PER_BURST > 1) ? $clog2(STEPS_PER_BURST) : 1;

    logic signed [15:0] r_offset;
    logic [19:0]        r_gain;
    logic signed [15:0] r_angle;
    logic               r_sw;
    logic signed [36:0] r_prod;
    logic signed [39:0] r_sum;
    logic signed [15:0] r_pos;
    logic signed [15:0] r_target;
    t_dir               r_dir;
    logic [IDX_W-1:0]   r_idx;
    logic               r_ovalid;
    logic [3:0]         r_ocoils;
    logic signed [15:0] r_opos;
    logic               r_ofin;
    logic               r_olast;

    logic signed [36:0] n_prod;
    logic signed [39:0] n_sum;
    logic signed [19:0] quot;
    logic signed [15:0] n_target;
    logic signed [15:0] pos_inc;
    logic signed [15:0] pos_dec;
    logic signed [15:0] pos_step;
    logic               last_idx;
    logic               moving;
    logic [2:0]         tab_idx;

    assign n_prod = r_angle * $signed({1'b0, r_gain});
    assign n_sum = {{3{r_offset[15]}}, r_offset, {FRAC_BITS{1'b0}}}
                 + {{3{r_prod[36]}}, r_prod};
    assign quot = {r_sum[39], r_sum[39:FRAC_BITS]}
                + {19'd0, r_sum[39] & (|r_sum[FRAC_BITS-1:0])};

    always_comb begin
        if (quot > 20'sd32767) begin
            n_target = 16'sh7fff;
        end else if (quot < -20'sd32768) begin
            n_target = 16'sh8000;
        end else begin
            n_target = quot[15:0];
        end
    end

    assign pos_inc = r_pos + 16'sd1;
    assign pos_dec = r_pos - 16'sd1;
    assign pos_step = i_cmd.step_cw ? pos_dec : pos_inc;
    assign last_idx = (r_idx == IDX_W'(STEPS_PER_BURST - 1));
    assign moving = (r_dir == DIR_CCW) || (r_dir == DIR_CW);
    assign tab_idx = 3'(r_idx);

    assign o_stat.dir = r_dir;
    assign o_stat.ccw_reached = (r_pos >= r_target);
    assign o_stat.cw_reached = (r_pos <= r_target);
    assign o_stat.done_up = (pos_inc >= r_target) || last_idx;
    assign o_stat.done_dn = (pos_dec <= r_target) || last_idx;
    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_stat.sw = r_sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
            r_gain <= GAIN_RST;
            r_pos <= '0;
            r_target <= '0;
            r_dir <= DIR_STOP;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TARGET_OFFSET: r_offset <= i_cfg_data[15:0];
                    default: r_gain <= i_cfg_data;
                endcase
            end
            if (i_cmd.sat) begin
                r_target <= n_target;
            end else if (i_cmd.home_start) begin
                r_target <= '0;
            end
            if (i_cmd.set_dir) begin
                if (r_pos < r_target) begin
                    r_dir <= DIR_CCW;
                end else if (r_pos > r_target) begin
                    r_dir <= DIR_CW;
                end
            end else if (i_cmd.stop_dir) begin
                r_dir <= DIR_STOP;
            end
            if (i_cmd.step) begin
                r_pos <= pos_step;
            end else if (i_cmd.home_start && r_sw) begin
                r_pos <= HOME_START_POS;
            end else if (i_cmd.clr_pos) begin
                r_pos <= '0;
            end
            if (i_cmd.step || i_cmd.emit_off) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_angle <= i_angle;
            r_sw <= i_switch_high;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.step) begin
            r_ocoils <= i_cmd.step_cw ? cw_coils(tab_idx) : ccw_coils(tab_idx);
            r_opos <= pos_step;
            r_ofin <= !moving;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_off) begin
            r_ocoils <= 4'h0;
            r_opos <= i_cmd.clr_pos ? 16'sd0 : r_pos;
            r_ofin <= !moving;
            r_olast <= i_cmd.off_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_coils = r_ocoils;
    assign o_position = r_opos;
    assign o_finished = r_ofin;
    assign o_last = r_olast;

endmodule

@@ rtl/shsp_ctrl.sv @@
// Controller state machine of the positioner.
module shsp_ctrl
    import shsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_cmd,
    output logic       o_in_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_cw;
    logic   n_cw;
    logic   r_home;
    logic   n_home;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cw <= 1'b0;
            r_home <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cw <= n_cw;
            r_home <= n_home;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cw = r_cw;
        n_home = r_home;
        o_cmd = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    case (t_cmd'(i_in_cmd))
                        CMD_SET_ANGLE: n_state = S_MUL;
                        CMD_UPDATE: begin
                            n_home = 1'b0;
                            n_state = S_UPD;
                        end
                        CMD_HOME: begin
                            n_home = 1'b1;
                            n_state = S_HOME;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state = S_DIR;
            end
            S_DIR: begin
                o_cmd.set_dir = 1'b1;
                n_state = S_IDLE;
            end
            S_UPD: begin
                case (i_stat.dir)
                    DIR_CCW: begin
                        if (i_stat.ccw_reached) begin
                            o_cmd.stop_dir = 1'b1;
                            n_state = S_OFF;
                        end else begin
                            n_cw = 1'b0;
                            n_state = S_STEP;
                        end
                    end
                    DIR_CW: begin
                        if (i_stat.cw_reached) begin
                            o_cmd.stop_dir = 1'b1;
                            n_state = S_OFF;
                        end else begin
                            n_cw = 1'b1;
                            n_state = S_STEP;
                        end
                    end
                    default: n_state = S_OFF;
                endcase
            end
            S_STEP: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    o_cmd.step_cw = r_cw;
                    if (r_cw ? i_stat.done_dn : i_stat.done_up) begin
                        n_state = S_OFF;
                    end
                end
            end
            S_HOME: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_off = 1'b1;
                    o_cmd.home_start = 1'b1;
                    if (i_stat.sw) begin
                        n_cw = 1'b1;
                        n_state = S_STEP;
                    end else begin
                        n_state = S_OFF;
                    end
                end
            end
            S_OFF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_off = 1'b1;
                    o_cmd.off_last = 1'b1;
                    o_cmd.clr_pos = r_home;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/stepper_half_step_positioner_top.sv @@
// Top level of the half-step stepper positioner.
//
// Channel   Direction  Handshake                Payload
// s_*       in         i_s_tvalid / o_s_tready  tdata: angle, switch_high; tuser: cmd
// m_*       out        o_m_tvalid / i_m_tready  tdata: coils, position, finished; tlast
// cfg_*     in         i_cfg_we                 index 0 target_offset, 1 angle_gain
//
// A set_angle item steps through multiply, add, saturate and direction.
// An update item gives its steps and a closing off result; a home item adds an off result before any steps.
// One result leaves per cycle through a single output register; a stalled output
// stops the state machine until the result is taken.
// Reset is synchronous and restores the registers and an empty output.
module stepper_half_step_positioner_top
    import shsp_pkg::*;
#(
    parameter int STEPS_PER_BURST = STEPS_PER_BURST_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // angle [15:0], switch_high [16], zero [23:17]
    input  logic [1:0]  i_s_tuser,   // cmd [1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // coils [3:0], position [19:4], finished [20], zero [23:21]
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [19:0] i_cfg_data
);

    t_dp_cmd            dp_cmd;
    t_dp_stat           dp_stat;
    logic [3:0]         coils;
    logic signed [15:0] position;
    logic               finished;

    shsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_cmd   (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    shsp_dp #(
        .STEPS_PER_BURST (STEPS_PER_BURST)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_angle       (i_s_tdata[15:0]),
        .i_switch_high (i_s_tdata[16]),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_coils       (coils),
        .o_position    (position),
        .o_finished    (finished),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, finished, position, coils};

endmodule

@@ rtl/shsp_checker.sv @@
// Port-level checker of the positioner and its binding to the top level.
`include "assert_macros.svh"

module shsp_checker
    import shsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    logic known_cmd;
    logic cmd_accept;

    assign known_cmd = (i_s_tuser == CMD_SET_ANGLE) || (i_s_tuser == CMD_UPDATE)
                    || (i_s_tuser == CMD_HOME);
    assign cmd_accept = i_s_tvalid && o_s_tready && known_cmd;

    // A command item keeps the input closed on the following cycle.
    `ASSERT_NXT(a_busy_after_item, cmd_accept, !o_s_tready)

    // The closing result of an item always has its coils switched off.
    `ASSERT_IMP(a_last_coils_off, o_m_tvalid && (o_m_tdata[3:0] != 4'd0), !o_m_tlast)

    `ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    `ASSERT_RST(a_reset_empty, !o_m_tvalid)

endmodule

bind stepper_half_step_positioner_top shsp_checker u_shsp_checker (.*);

@@ tb/sv/tb_stepper_half_step_positioner_top.sv @@
// Self-checking testbench for the half-step stepper positioner: directed table, random motion.
`timescale 1ns / 100ps

module tb_stepper_half_step_positioner_top;
    import shsp_pkg::*;

    localparam logic [1:0] CMD_RSVD = 2'd3;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS = 33;

    localparam logic [3:0] CCW_SEQ [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9};
    localparam logic [3:0] CW_SEQ [8] = '{4'h1, 4'h9, 4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3};

    typedef struct packed {
        logic [3:0]  coils;
        logic [15:0] position;
        logic        finished;
        logic        last;
    } t_coil_res;

    typedef enum logic {ROW_ITEM, ROW_REGS} t_row_kind;
    typedef enum logic [1:0] {EXP_PREDICTED, EXP_NONE, EXP_ONE} t_exp_src;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  cmd;
        logic [15:0] angle;
        logic        sw;
        logic [15:0] offs;
        logic [19:0] gain;
        t_exp_src    src;
        t_coil_res   want;
    } t_dir_row;

    localparam t_coil_res STOP_AT_ZERO = '{4'h0, 16'h0000, 1'b1, 1'b1};
    localparam t_coil_res NO_RES = '0;

    localparam int N_ROWS = 29;
    localparam t_dir_row DIRECTED [N_ROWS] = '{
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_ONE, STOP_AT_ZERO},
        '{ROW_ITEM, CMD_RSVD,      16'hffff, 1'b1, 16'h0000, 20'd0, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_HOME,      16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_ONE, STOP_AT_ZERO},
        '{ROW_ITEM, CMD_HOME,      16'h0000, 1'b1, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h7fff, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h8000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_REGS, CMD_UPDATE,    16'h0000, 1'b0, 16'h8000, 20'hfffff, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h8000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h7fff, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_REGS, CMD_UPDATE,    16'h0000, 1'b0, 16'h7fff, 20'd0, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h1234, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_REGS, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_HOME,      16'h0000, 1'b1, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h5555, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_ONE, STOP_AT_ZERO},
        '{ROW_REGS, CMD_UPDATE,    16'h0000, 1'b0, 16'h0003, 20'd0, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_REGS, CMD_UPDATE,    16'h0000, 1'b0, 16'hfffe, 20'd256, EXP_NONE, NO_RES},
        '{ROW_ITEM, CMD_SET_ANGLE, 16'h2000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_PREDICTED, NO_RES},
        '{ROW_ITEM, CMD_UPDATE,    16'h0000, 1'b0, 16'h0000, 20'd0, EXP_ONE,
          '{4'h0, 16'hffff, 1'b1, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // angle [15:0], switch_high [16], zero [23:17]
    logic [1:0]  i_s_tuser = '0;   // cmd [1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // coils [3:0], position [19:4], finished [20], zero [23:21]
    logic        o_m_tlast;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [19:0] i_cfg_data = '0;

    logic signed [15:0] tgt_offs = OFFSET_RST;
    logic [19:0]        ang_gain = GAIN_RST;
    logic signed [15:0] pos = '0;
    logic signed [15:0] tgt = '0;
    t_dir               dir = DIR_STOP;

    t_coil_res pending_coils [$];
    int        errs = 0;
    int        quiet = 0;
    int        hold_reqs = 0;
    int        holds_done = 0;
    logic      src_idle = 1'b1;
    logic      snk_idle = 1'b1;

    stepper_half_step_positioner_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_coil_res snap(input logic [3:0] coils, input logic last);
        t_coil_res r;
        r.coils = coils;
        r.position = pos;
        r.finished = !(dir == DIR_CCW || dir == DIR_CW);
        r.last = last;
        return r;
    endfunction

    function automatic void predict_motion(input logic [1:0] cmd, input logic signed [15:0] angle,
                                           input logic sw, output t_coil_res res [$]);
        longint acc;
        longint quo;
        res = {};
        case (cmd)
            CMD_SET_ANGLE: begin
                acc = longint'(tgt_offs) * 64'sd2097152 + longint'(angle) * longint'(ang_gain);
                quo = acc / 64'sd2097152;
                if (quo > 64'sd32767) begin
                    tgt = 16'sh7fff;
                end else if (quo < -64'sd32768) begin
                    tgt = 16'sh8000;
                end else begin
                    tgt = 16'(quo);
                end
                if (pos < tgt) begin
                    dir = DIR_CCW;
                end else if (pos > tgt) begin
                    dir = DIR_CW;
                end
            end
            CMD_UPDATE: begin
                if (dir == DIR_CCW) begin
                    if (pos >= tgt) begin
                        dir = DIR_STOP;
                    end else begin
                        for (int i = 0; i < STEPS_PER_BURST_DEF; i++) begin
                            pos = pos + 16'sd1;
                            res.push_back(snap(CCW_SEQ[i % 8], 1'b0));
                            if (pos >= tgt) break;
                        end
                    end
                end else if (dir == DIR_CW) begin
                    if (pos <= tgt) begin
                        dir = DIR_STOP;
                    end else begin
                        for (int i = 0; i < STEPS_PER_BURST_DEF; i++) begin
                            pos = pos - 16'sd1;
                            res.push_back(snap(CW_SEQ[i % 8], 1'b0));
                            if (pos <= tgt) break;
                        end
                    end
                end
                res.push_back(snap(4'h0, 1'b1));
            end
            CMD_HOME: begin
                res.push_back(snap(4'h0, 1'b0));
                tgt = '0;
                if (sw) begin
                    pos = HOME_START_POS;
                    for (int i = 0; i < STEPS_PER_BURST_DEF; i++) begin
                        pos = pos - 16'sd1;
                        res.push_back(snap(CW_SEQ[i % 8], 1'b0));
                        if (pos <= tgt) break;
                    end
                end
                pos = '0;
                res.push_back(snap(4'h0, 1'b1));
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] angle, input logic sw,
                             input t_exp_src src, input t_coil_res want);
        t_coil_res res [$];
        if (src_idle && $urandom_range(0, 2) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {7'd0, sw, angle};
        i_s_tuser <= cmd;
        do @(posedge i_clk); while (!o_s_tready);
        predict_motion(cmd, angle, sw, res);
        if (src == EXP_PREDICTED) begin
            foreach (res[k]) pending_coils.push_back(res[k]);
        end else if (src == EXP_ONE) begin
            pending_coils.push_back(want);
        end
    endtask

    // Drains the results and leaves time for an item that gives no result to finish.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_coils.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] offs, input logic [19:0] gain);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TARGET_OFFSET;
        i_cfg_data <= {{4{offs[15]}}, offs};
        @(posedge i_clk);
        i_cfg_idx <= CFG_ANGLE_GAIN;
        i_cfg_data <= gain;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tgt_offs = offs;
        ang_gain = gain;
    endtask

    initial begin : stimulus
        t_dir_row    row;
        int          r;
        logic [15:0] offs;
        logic [19:0] gain;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < N_ROWS; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_REGS) begin
                write_regs(row.offs, row.gain);
            end else begin
                send_item(row.cmd, row.angle, row.sw, row.src, row.want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            src_idle = (ph < 5) && (ph != 2);
            snk_idle = (ph < 5) && (ph != 1);
            case ($urandom_range(0, 4))
                0: offs = 16'h8000;
                1: offs = 16'h7fff;
                2, 3: offs = 16'(int'($urandom_range(0, 600)) - 300);
                default: offs = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: gain = '0;
                1: gain = 20'hfffff;
                2: gain = GAIN_RST;
                3: gain = 20'($urandom_range(0, 4095));
                default: gain = 20'($urandom);
            endcase
            if (ph == 0) begin
                offs = OFFSET_RST;
                gain = GAIN_RST;
            end
            if (ph == 3) begin
                // Distant target, then a long output stall while updates keep arriving.
                write_regs(16'd20000, 20'd0);
                send_item(CMD_SET_ANGLE, 16'($urandom), 1'($urandom), EXP_PREDICTED, NO_RES);
                hold_reqs++;
                repeat (6) send_item(CMD_UPDATE, 16'($urandom), 1'($urandom),
                                     EXP_PREDICTED, NO_RES);
                settle();
            end else begin
                write_regs(offs, gain);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 18) begin
                    send_item(CMD_SET_ANGLE, 16'($urandom), 1'($urandom), EXP_PREDICTED, NO_RES);
                end else if (r < 80) begin
                    send_item(CMD_UPDATE, 16'($urandom), 1'($urandom), EXP_PREDICTED, NO_RES);
                end else if (r < 96) begin
                    send_item(CMD_HOME, 16'($urandom), 1'($urandom), EXP_PREDICTED, NO_RES);
                end else begin
                    send_item(CMD_RSVD, 16'($urandom), 1'($urandom), EXP_PREDICTED, NO_RES);
                end
            end
        end

        settle();
        if (errs == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : sink_ready
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
                i_m_tready <= 1'b1;
            end else if (snk_idle && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 15);
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_coil_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_coils.size() == 0) begin
                $display("%0t: expected no result, got tdata %h tlast %b", $time,
                         o_m_tdata, o_m_tlast);
                errs++;
            end else begin
                want = pending_coils.pop_front();
                if (o_m_tdata[3:0] !== want.coils) begin
                    $display("%0t: coils expected %h, got %h", $time, want.coils, o_m_tdata[3:0]);
                    errs++;
                end
                if (o_m_tdata[19:4] !== want.position) begin
                    $display("%0t: position expected %0d, got %0d", $time,
                             $signed(want.position), $signed(o_m_tdata[19:4]));
                    errs++;
                end
                if (o_m_tdata[20] !== want.finished) begin
                    $display("%0t: finished expected %b, got %b", $time, want.finished,
                             o_m_tdata[20]);
                    errs++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: tlast expected %b, got %b", $time, want.last, o_m_tlast);
                    errs++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
